// ----- rtl/pws_pkg.sv -----
`timescale 1ns / 1ps

package pws_pkg;

   localparam int WEIGHT_W    = 16;
   localparam int SCORE_W     = 21;
   localparam int POS_W       = 16;
   localparam int CHAR_W      = 8;
   localparam int INDEX_W     = 7;
   localparam int COL_W       = 5;
   localparam int BASE_W      = 2;
   localparam int LEN_W       = 6;
   localparam int SPAN_W      = 18;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic signed [SCORE_W-1:0] SCORE_HI = SCORE_W'(1048575);
   localparam logic signed [SCORE_W-1:0] SCORE_LO = SCORE_W'(-1048576);

   localparam logic [CSR_INDEX_W-1:0] CSR_MOTIF_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRONT_SKIP   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACK_SKIP    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEQ_LENGTH   = 2'd3;

   localparam logic MODE_LOAD_WEIGHT = 1'b0;
   localparam logic MODE_PUSH_CHAR   = 1'b1;

   localparam logic [CHAR_W-1:0] CHAR_A_UP = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_A_LO = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_G_UP = 8'h47;
   localparam logic [CHAR_W-1:0] CHAR_G_LO = 8'h67;
   localparam logic [CHAR_W-1:0] CHAR_C_UP = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_C_LO = 8'h63;
   localparam logic [CHAR_W-1:0] CHAR_T_UP = 8'h54;
   localparam logic [CHAR_W-1:0] CHAR_T_LO = 8'h74;

   localparam logic [BASE_W-1:0] BASE_A = 2'd0;
   localparam logic [BASE_W-1:0] BASE_G = 2'd1;
   localparam logic [BASE_W-1:0] BASE_C = 2'd2;
   localparam logic [BASE_W-1:0] BASE_T = 2'd3;

   typedef struct packed {
      logic              hit;
      logic [BASE_W-1:0] code;
   } base_type;

   typedef struct packed {
      logic                       shift;
      logic                       weight_we;
      logic [COL_W-1:0]           weight_col;
      logic [BASE_W-1:0]          weight_base;
      logic signed [WEIGHT_W-1:0] weight_value;
      base_type                   base;
      logic [LEN_W-1:0]           len;
   } chain_ctrl_type;

   typedef struct packed {
      logic                     load;
      logic                     shift;
      logic [POS_W-1:0]         position;
      logic [LEN_W-1:0]         len;
      logic [POS_W-1:0]         front_skip;
      logic signed [SPAN_W-1:0] win_hi;
   } drain_ctrl_type;

   function automatic base_type base_decode(input logic [CHAR_W-1:0] ch);
      base_type result;
      result.hit = 1'b1;
      case (ch)
         CHAR_A_UP, CHAR_A_LO: result.code = BASE_A;
         CHAR_G_UP, CHAR_G_LO: result.code = BASE_G;
         CHAR_C_UP, CHAR_C_LO: result.code = BASE_C;
         CHAR_T_UP, CHAR_T_LO: result.code = BASE_T;
         default: begin
            result.hit  = 1'b0;
            result.code = BASE_A;
         end
      endcase
      return result;
   endfunction

   function automatic logic window_scored(input logic signed [SPAN_W-1:0] start,
                                          input logic [POS_W-1:0] front_skip,
                                          input logic signed [SPAN_W-1:0] win_hi);
      logic signed [SPAN_W-1:0] lo;
      lo = $signed({2'b00, front_skip});
      return (start >= lo) && (start < win_hi);
   endfunction

   function automatic logic [POS_W-1:0] window_offset(input logic signed [SPAN_W-1:0] start,
                                                      input logic [POS_W-1:0] front_skip);
      logic signed [SPAN_W-1:0] diff;
      diff = start - $signed({2'b00, front_skip});
      return diff[POS_W-1:0];
   endfunction

endpackage

// ----- rtl/pws_req_if.sv -----
`timescale 1ns / 1ps

interface pws_req_if import pws_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       mode;
   logic [INDEX_W-1:0]         weight_index;
   logic signed [WEIGHT_W-1:0] weight_value;
   logic [CHAR_W-1:0]          base_char;

   modport source (output valid, output mode, output weight_index, output weight_value,
                   output base_char, input ready);
   modport sink (input valid, input mode, input weight_index, input weight_value,
                 input base_char, output ready);
endinterface

// ----- rtl/pws_rsp_if.sv -----
`timescale 1ns / 1ps

interface pws_rsp_if import pws_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SCORE_W-1:0] window_score;
   logic [POS_W-1:0]          window_position;
   logic                      last_of_run;

   modport source (output valid, output window_score, output window_position,
                   output last_of_run, input ready);
   modport sink (input valid, input window_score, input window_position,
                 input last_of_run, output ready);
endinterface

// ----- rtl/pssm_window_scorer_unit.sv -----
// A character's window result is registered in the cell sums and stage B, then in the output register.
// One item per cycle while stage B can advance; the flush row or a stalled output register holds requests.
// The final character of a sequence drains its open windows through the flush row,
// while one more character waits in the result stage.
// Reset (synchronous): configuration registers to defaults, position counter and handshakes cleared;
// weights are undefined until loaded.
`timescale 1ns / 1ps

module pssm_window_scorer_unit import pws_pkg::*; #(
   parameter int MAX_COLUMNS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   pws_req_if.sink                req_bus,
   pws_rsp_if.source              rsp_bus,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int SUM_W  = (WEIGHT_W + $clog2(MAX_COLUMNS) > SCORE_W) ?
                           WEIGHT_W + $clog2(MAX_COLUMNS) : SCORE_W;
   localparam int CIDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam logic [MAX_COLUMNS-1:0] DRAIN_TOP = MAX_COLUMNS'(1) << (MAX_COLUMNS - 1);
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(SCORE_HI);
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(SCORE_LO);

   function automatic logic signed [SCORE_W-1:0] saturate(input logic signed [SUM_W-1:0] v);
      logic signed [SCORE_W-1:0] r;
      if (v > SAT_HI) begin
         r = SCORE_HI;
      end else if (v < SAT_LO) begin
         r = SCORE_LO;
      end else begin
         r = v[SCORE_W-1:0];
      end
      return r;
   endfunction

   logic [LEN_W-1:0] motif_length_ff;
   logic [POS_W-1:0] front_skip_ff;
   logic [POS_W-1:0] back_skip_ff;
   logic [POS_W-1:0] seq_length_ff;
   logic [POS_W-1:0] char_count_ff, char_count_in;

   logic             b_valid_ff, b_valid_in;
   logic             b_final_ff, b_final_in;
   logic [POS_W-1:0] b_p_ff, b_p_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SCORE_W-1:0] score_ff, score_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic                      last_ff, last_in;

   logic [LEN_W-1:0]         len_eff;
   logic signed [SPAN_W-1:0] win_hi;
   logic                     accept, char_acc, weight_acc, final_char;
   logic                     out_free, flush_busy, b_adv, b_hit;
   logic                     drain_shift, drain_emit;
   logic signed [SPAN_W-1:0] b_start;
   logic signed [SUM_W-1:0]  b_sum;

   chain_ctrl_type chain_ctrl;
   drain_ctrl_type drain_ctrl;

   logic signed [SUM_W-1:0] cell_sum [MAX_COLUMNS];
   logic signed [SUM_W-1:0] fl_sum [MAX_COLUMNS];
   logic [POS_W-1:0]        fl_pos [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0]  fl_valid, fl_hit;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         motif_length_ff <= LEN_W'(1);
         front_skip_ff   <= '0;
         back_skip_ff    <= '0;
         seq_length_ff   <= POS_W'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MOTIF_LENGTH: motif_length_ff <= csr_write_data[LEN_W-1:0];
            CSR_FRONT_SKIP:   front_skip_ff   <= csr_write_data[POS_W-1:0];
            CSR_BACK_SKIP:    back_skip_ff    <= csr_write_data[POS_W-1:0];
            CSR_SEQ_LENGTH:   seq_length_ff   <= csr_write_data[POS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (motif_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if ({1'b0, motif_length_ff} > (LEN_W + 1)'(MAX_COLUMNS)) begin
         len_eff = LEN_W'(MAX_COLUMNS);
      end else begin
         len_eff = motif_length_ff;
      end
      win_hi = $signed({2'b00, seq_length_ff}) - $signed({2'b00, back_skip_ff});
   end

   // handshake and stage control
   always_comb begin
      out_free    = !rsp_valid_ff || rsp_bus.ready;
      flush_busy  = |fl_valid;
      b_adv       = b_valid_ff && !flush_busy && out_free;
      req_bus.ready = !b_valid_ff || b_adv;
      accept      = req_bus.valid && req_bus.ready;
      char_acc    = accept && (req_bus.mode == MODE_PUSH_CHAR);
      weight_acc  = accept && (req_bus.mode == MODE_LOAD_WEIGHT);
      final_char  = ({1'b0, char_count_ff} + 17'd1) >= {1'b0, seq_length_ff};
      drain_emit  = fl_valid[MAX_COLUMNS-1] && out_free;
      drain_shift = flush_busy && (!fl_valid[MAX_COLUMNS-1] || out_free);
   end

   always_comb begin
      chain_ctrl.shift        = char_acc;
      chain_ctrl.weight_we    = weight_acc;
      chain_ctrl.weight_col   = req_bus.weight_index[INDEX_W-1:BASE_W];
      chain_ctrl.weight_base  = req_bus.weight_index[BASE_W-1:0];
      chain_ctrl.weight_value = req_bus.weight_value;
      chain_ctrl.base         = base_decode(req_bus.base_char);
      chain_ctrl.len          = len_eff;

      drain_ctrl.load       = b_adv && b_final_ff;
      drain_ctrl.shift      = drain_shift;
      drain_ctrl.position   = b_p_ff;
      drain_ctrl.len        = len_eff;
      drain_ctrl.front_skip = front_skip_ff;
      drain_ctrl.win_hi     = win_hi;
   end

   for (genvar k = 0; k < MAX_COLUMNS; k++) begin : g_row
      logic signed [SUM_W-1:0] sum_prev;
      logic                    drain_prev_valid;
      logic signed [SUM_W-1:0] drain_prev_sum;
      logic [POS_W-1:0]        drain_prev_pos;

      if (k == 0) begin : g_head
         assign sum_prev         = '0;
         assign drain_prev_valid = 1'b0;
         assign drain_prev_sum   = '0;
         assign drain_prev_pos   = '0;
      end else begin : g_link
         assign sum_prev         = cell_sum[k-1];
         assign drain_prev_valid = fl_valid[k-1];
         assign drain_prev_sum   = fl_sum[k-1];
         assign drain_prev_pos   = fl_pos[k-1];
      end

      pws_cell #(.INDEX(k), .SUM_W(SUM_W)) u_cell (
         .clock    (clock),
         .ctrl     (chain_ctrl),
         .sum_prev (sum_prev),
         .sum_out  (cell_sum[k])
      );

      pws_drain_cell #(.INDEX(k), .SUM_W(SUM_W)) u_drain (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (drain_ctrl),
         .load_sum   (cell_sum[k]),
         .prev_valid (drain_prev_valid),
         .prev_sum   (drain_prev_sum),
         .prev_pos   (drain_prev_pos),
         .load_hit   (fl_hit[k]),
         .valid_out  (fl_valid[k]),
         .sum_out    (fl_sum[k]),
         .pos_out    (fl_pos[k])
      );
   end

   // result stage: window completed by the character in stage B
   always_comb begin
      b_start = $signed({2'b00, b_p_ff}) - $signed({12'd0, len_eff}) + 18'sd1;
      b_hit   = window_scored(b_start, front_skip_ff, win_hi);
      b_sum   = cell_sum[CIDX_W'(len_eff - LEN_W'(1))];
   end

   always_comb begin
      char_count_in = char_count_ff;
      b_valid_in    = b_valid_ff;
      b_final_in    = b_final_ff;
      b_p_in        = b_p_ff;
      if (b_adv) begin
         b_valid_in = 1'b0;
      end
      if (char_acc) begin
         char_count_in = final_char ? '0 : char_count_ff + POS_W'(1);
         b_valid_in    = 1'b1;
         b_final_in    = final_char;
         b_p_in        = char_count_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      score_in     = score_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (b_adv && b_hit) begin
         rsp_valid_in = 1'b1;
         score_in     = saturate(b_sum);
         pos_in       = window_offset(b_start, front_skip_ff);
         last_in      = !(b_final_ff && (|fl_hit));
      end else if (drain_emit) begin
         rsp_valid_in = 1'b1;
         score_in     = saturate(fl_sum[MAX_COLUMNS-1]);
         pos_in       = fl_pos[MAX_COLUMNS-1];
         last_in      = (fl_valid & ~DRAIN_TOP) == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff <= '0;
         b_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         char_count_ff <= char_count_in;
         b_valid_ff    <= b_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_final_ff <= b_final_in;
      b_p_ff     <= b_p_in;
      score_ff   <= score_in;
      pos_ff     <= pos_in;
      last_ff    <= last_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.window_score    = score_ff;
   assign rsp_bus.window_position = pos_ff;
   assign rsp_bus.last_of_run     = last_ff;

   assert property (@(posedge clock) disable iff (reset) !(b_adv && b_hit && drain_emit))
      else $error("result stage and flush row load the output register together");

   assert property (@(posedge clock) disable iff (reset)
                    drain_ctrl.load |=> !fl_valid[MAX_COLUMNS-1])
      else $error("flush row top loaded with a window");

   assert property (@(posedge clock) disable iff (reset)
                    (b_valid_ff && !b_adv) |=> (b_valid_ff && $stable(b_p_ff)))
      else $error("stalled character lost from result stage");

endmodule

// ----- rtl/pws_cell.sv -----
`timescale 1ns / 1ps

module pws_cell import pws_pkg::*; #(
   parameter int INDEX = 0,
   parameter int SUM_W = 21
) (
   input  logic                    clock,
   input  chain_ctrl_type          ctrl,
   input  logic signed [SUM_W-1:0] sum_prev,
   output logic signed [SUM_W-1:0] sum_out
);

   logic signed [WEIGHT_W-1:0] weight_ff [4];
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [SUM_W-1:0]    sum_in;
   logic signed [WEIGHT_W-1:0] addend;
   logic                       active;

   always_comb begin
      active = int'(ctrl.len) > INDEX;
      addend = (ctrl.base.hit && active) ? weight_ff[ctrl.base.code] : '0;
      sum_in = sum_prev + SUM_W'(addend);
   end

   always_ff @(posedge clock) begin
      if (ctrl.weight_we && (int'(ctrl.weight_col) == INDEX)) begin
         weight_ff[ctrl.weight_base] <= ctrl.weight_value;
      end
      if (ctrl.shift) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_out = sum_ff;

endmodule

// ----- rtl/pws_drain_cell.sv -----
`timescale 1ns / 1ps

module pws_drain_cell import pws_pkg::*; #(
   parameter int INDEX = 0,
   parameter int SUM_W = 21
) (
   input  logic                    clock,
   input  logic                    reset,
   input  drain_ctrl_type          ctrl,
   input  logic signed [SUM_W-1:0] load_sum,
   input  logic                    prev_valid,
   input  logic signed [SUM_W-1:0] prev_sum,
   input  logic [POS_W-1:0]        prev_pos,
   output logic                    load_hit,
   output logic                    valid_out,
   output logic signed [SUM_W-1:0] sum_out,
   output logic [POS_W-1:0]        pos_out
);

   logic                     valid_ff, valid_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic signed [SPAN_W-1:0] start;

   always_comb begin
      start    = $signed({2'b00, ctrl.position}) - SPAN_W'(INDEX);
      load_hit = (int'(ctrl.len) > INDEX + 1) && window_scored(start, ctrl.front_skip, ctrl.win_hi);
      valid_in = valid_ff;
      sum_in   = sum_ff;
      pos_in   = pos_ff;
      if (ctrl.load) begin
         valid_in = load_hit;
         sum_in   = load_sum;
         pos_in   = window_offset(start, ctrl.front_skip);
      end else if (ctrl.shift) begin
         valid_in = prev_valid;
         sum_in   = prev_sum;
         pos_in   = prev_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      pos_ff <= pos_in;
   end

   assign valid_out = valid_ff;
   assign sum_out   = sum_ff;
   assign pos_out   = pos_ff;

endmodule
